// ----- design/eegc_pkg.sv -----
package eegc_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int MIN_DIM        = 3;
    localparam int RESET_DIM      = 256;

    localparam int CMD_W      = 2;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [PIX_W-1:0] PIX_EDGE = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_SHIFT = 5'b00100,
        S_EVAL  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    // Neighbor flags, bit order: 0 NW, 1 N, 2 NE, 3 W, 4 E, 5 SW, 6 S, 7 SE.
    // Two set flags are 4-adjacent only for consecutive positions on the ring.
    function automatic logic is_endpoint(input logic [7:0] f);
        logic [3:0] n;
        logic       adj;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, f[i]};
        end
        adj = (f[0] & f[1]) | (f[1] & f[2]) | (f[2] & f[4]) | (f[4] & f[7]) |
              (f[7] & f[6]) | (f[6] & f[5]) | (f[5] & f[3]) | (f[3] & f[0]);
        return (n <= 4'd1) || ((n == 4'd2) && adj);
    endfunction

endpackage

// ----- design/eegc_ram.sv -----
module eegc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 65536,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- design/edge_endpoint_gap_closer.sv -----
// Edge endpoint gap closer. Command beats on the input channel either load
// the next edge byte (raster order), run one in-place gap closing pass, or
// read the next processed byte (raster order, last_pixel marks the final
// pixel of the frame). Load and read positions wrap after the last pixel and
// return to zero whenever a size register is written; sizes are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT. The frame lives in one simple dual-port RAM
// with a registered read. A read is issued to the RAM and its data returns
// into a two-deep output (output register plus skid), so a new read can be
// taken while an earlier one is still in flight, as long as the sink keeps
// up. A run holds the input channel for its whole length: each interior pixel
// takes three column reads through the single read port, one shift and one
// evaluation, plus a write-back of the whole 3x3 window when it is an
// endpoint; at the start of each row three columns are fetched to prime the
// 3x3 window. Pixels never loaded read back as whatever the RAM holds.
module edge_endpoint_gap_closer
    import eegc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [PIX_W-1:0]      i_pixel_in,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_last_pixel,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_value
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W = (RESET_DIM > MAX_WIDTH)  ? MAX_WIDTH  : RESET_DIM;
    localparam int RST_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

    // ---------------------------------------------------------------
    // Frame size (stored already clamped)
    // ---------------------------------------------------------------
    logic [WB-1:0] r_w, n_w;
    logic [HB-1:0] r_h, n_h;
    logic [CW-1:0] wm1, wm2;
    logic [RW-1:0] hm1, hm2;

    assign wm1 = CW'(r_w - WB'(1));
    assign wm2 = CW'(r_w - WB'(2));
    assign hm1 = RW'(r_h - HB'(1));
    assign hm2 = RW'(r_h - HB'(2));

    t_state r_state, n_state;

    logic cfg_acc;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_w = r_w;
        n_h = r_h;
        if (cfg_acc && (i_cfg_index == REG_WIDTH)) begin
            if (int'(i_cfg_value) < MIN_DIM) begin
                n_w = WB'(MIN_DIM);
            end else if (int'(i_cfg_value) > MAX_WIDTH) begin
                n_w = WB'(MAX_WIDTH);
            end else begin
                n_w = WB'(i_cfg_value);
            end
        end
        if (cfg_acc && (i_cfg_index == REG_HEIGHT)) begin
            if (int'(i_cfg_value) < MIN_DIM) begin
                n_h = HB'(MIN_DIM);
            end else if (int'(i_cfg_value) > MAX_HEIGHT) begin
                n_h = HB'(MAX_HEIGHT);
            end else begin
                n_h = HB'(i_cfg_value);
            end
        end
    end

    logic pos_clr;
    assign pos_clr = cfg_acc && ((i_cfg_index == REG_WIDTH) || (i_cfg_index == REG_HEIGHT));

    // ---------------------------------------------------------------
    // Command acceptance
    // ---------------------------------------------------------------
    logic       r_out_v, r_skid_v, r_rd_pend;
    logic [1:0] occ;
    logic       in_acc, ld_acc, run_acc, rd_acc;

    assign occ = {1'b0, r_out_v} + {1'b0, r_skid_v} + {1'b0, r_rd_pend};

    // reads need room for their beat; everything else only needs the RAM
    assign o_in_ready = (r_state == S_IDLE) &&
                        ((i_cmd != CMD_READ) || (occ <= 2'd1));
    assign in_acc  = i_in_valid && o_in_ready;
    assign ld_acc  = in_acc && (i_cmd == CMD_LOAD);
    assign run_acc = in_acc && (i_cmd == CMD_RUN);
    assign rd_acc  = in_acc && (i_cmd == CMD_READ);

    // ---------------------------------------------------------------
    // Load and read positions (linear address plus row/column)
    // ---------------------------------------------------------------
    logic [AW-1:0] r_ld_addr, r_rd_addr;
    logic [CW-1:0] r_ld_col,  r_rd_col;
    logic [RW-1:0] r_ld_row,  r_rd_row;
    logic          ld_last, rd_last;

    assign ld_last = (r_ld_col == wm1) && (r_ld_row == hm1);
    assign rd_last = (r_rd_col == wm1) && (r_rd_row == hm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WB'(RST_W);
            r_h       <= HB'(RST_H);
            r_ld_addr <= '0;
            r_ld_col  <= '0;
            r_ld_row  <= '0;
            r_rd_addr <= '0;
            r_rd_col  <= '0;
            r_rd_row  <= '0;
        end else begin
            r_w <= n_w;
            r_h <= n_h;
            if (pos_clr) begin
                r_ld_addr <= '0;
                r_ld_col  <= '0;
                r_ld_row  <= '0;
                r_rd_addr <= '0;
                r_rd_col  <= '0;
                r_rd_row  <= '0;
            end else begin
                if (ld_acc) begin
                    if (ld_last) begin
                        r_ld_addr <= '0;
                        r_ld_col  <= '0;
                        r_ld_row  <= '0;
                    end else if (r_ld_col == wm1) begin
                        r_ld_addr <= r_ld_addr + AW'(1);
                        r_ld_col  <= '0;
                        r_ld_row  <= r_ld_row + RW'(1);
                    end else begin
                        r_ld_addr <= r_ld_addr + AW'(1);
                        r_ld_col  <= r_ld_col + CW'(1);
                    end
                end
                if (rd_acc) begin
                    if (rd_last) begin
                        r_rd_addr <= '0;
                        r_rd_col  <= '0;
                        r_rd_row  <= '0;
                    end else if (r_rd_col == wm1) begin
                        r_rd_addr <= r_rd_addr + AW'(1);
                        r_rd_col  <= '0;
                        r_rd_row  <= r_rd_row + RW'(1);
                    end else begin
                        r_rd_addr <= r_rd_addr + AW'(1);
                        r_rd_col  <= r_rd_col + CW'(1);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Gap closing pass: 3x3 window slides along each interior row.
    // r_base is the linear address of (center row - 1, column 0).
    // ---------------------------------------------------------------
    logic [AW-1:0]    r_base, n_base;
    logic [CW-1:0]    r_rc, n_rc;     // center column
    logic [RW-1:0]    r_rr, n_rr;     // center row
    logic [CW-1:0]    r_fx, n_fx;     // column being fetched
    logic [1:0]       r_k, n_k;       // window row being fetched
    logic [1:0]       r_fill, n_fill; // columns shifted in so far
    logic [1:0]       r_wi, n_wi;     // write-back row
    logic [1:0]       r_wj, n_wj;     // write-back column
    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] r_nc0, r_nc1;

    logic [AW-1:0]    wv;
    logic [AW-1:0]    base1, base2;
    logic [AW-1:0]    fetch_addr, wb_addr;
    logic [CW-1:0]    wb_col;
    logic [PIX_W-1:0] rd_data;
    logic [7:0]       nb_edge;
    logic             hit;

    assign wv    = AW'(r_w);
    assign base1 = r_base + wv;
    assign base2 = r_base + (wv << 1);

    always_comb begin
        case (r_k)
            2'd0:    fetch_addr = r_base + AW'(r_fx);
            2'd1:    fetch_addr = base1 + AW'(r_fx);
            default: fetch_addr = base2 + AW'(r_fx);
        endcase
    end

    assign wb_col = r_rc - CW'(1) + CW'(r_wj);
    always_comb begin
        case (r_wi)
            2'd0:    wb_addr = r_base + AW'(wb_col);
            2'd1:    wb_addr = base1 + AW'(wb_col);
            default: wb_addr = base2 + AW'(wb_col);
        endcase
    end

    assign nb_edge = {r_win[2][2] == PIX_EDGE, r_win[2][1] == PIX_EDGE,
                      r_win[2][0] == PIX_EDGE, r_win[1][2] == PIX_EDGE,
                      r_win[1][0] == PIX_EDGE, r_win[0][2] == PIX_EDGE,
                      r_win[0][1] == PIX_EDGE, r_win[0][0] == PIX_EDGE};
    assign hit = (r_win[1][1] != PIX_ZERO) && is_endpoint(nb_edge);

    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_rc    = r_rc;
        n_rr    = r_rr;
        n_fx    = r_fx;
        n_k     = r_k;
        n_fill  = r_fill;
        n_wi    = r_wi;
        n_wj    = r_wj;
        case (r_state)
            S_IDLE: begin
                if (run_acc) begin
                    n_state = S_FETCH;
                    n_base  = '0;
                    n_rr    = RW'(1);
                    n_rc    = CW'(1);
                    n_fx    = '0;
                    n_k     = '0;
                    n_fill  = '0;
                end
            end
            S_FETCH: begin
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_k = '0;
                if (r_fill == 2'd2) begin
                    n_state = S_EVAL;
                end else begin
                    n_state = S_FETCH;
                    n_fill  = r_fill + 2'd1;
                    n_fx    = r_fx + CW'(1);
                end
            end
            S_EVAL, S_WRITE: begin
                if ((r_state == S_EVAL) && hit) begin
                    n_state = S_WRITE;
                    n_wi    = '0;
                    n_wj    = '0;
                end else if ((r_state == S_WRITE) &&
                             !((r_wi == 2'd2) && (r_wj == 2'd2))) begin
                    if (r_wj == 2'd2) begin
                        n_wj = '0;
                        n_wi = r_wi + 2'd1;
                    end else begin
                        n_wj = r_wj + 2'd1;
                    end
                end else if (r_rc != wm2) begin
                    // next center on this row: fetch one new column
                    n_state = S_FETCH;
                    n_rc    = r_rc + CW'(1);
                    n_fx    = r_rc + CW'(2);
                    n_k     = '0;
                    n_fill  = 2'd2;
                end else if (r_rr != hm2) begin
                    // next row: prime three columns
                    n_state = S_FETCH;
                    n_rr    = r_rr + RW'(1);
                    n_base  = base1;
                    n_rc    = CW'(1);
                    n_fx    = '0;
                    n_k     = '0;
                    n_fill  = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_rc   <= n_rc;
        r_rr   <= n_rr;
        r_fx   <= n_fx;
        r_k    <= n_k;
        r_fill <= n_fill;
        r_wi   <= n_wi;
        r_wj   <= n_wj;
        if ((r_state == S_FETCH) && (r_k == 2'd1)) begin
            r_nc0 <= rd_data;
        end
        if ((r_state == S_FETCH) && (r_k == 2'd2)) begin
            r_nc1 <= rd_data;
        end
        if (r_state == S_SHIFT) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_nc0;
            r_win[1][2] <= r_nc1;
            r_win[2][2] <= rd_data;
        end else if ((r_state == S_EVAL) && hit) begin
            // mirror the write-back so later windows see it
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= PIX_EDGE;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Frame store
    // ---------------------------------------------------------------
    logic             mem_we;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [PIX_W-1:0] mem_wd;

    assign mem_we = ld_acc || (r_state == S_WRITE);
    assign mem_wa = (r_state == S_WRITE) ? wb_addr : r_ld_addr;
    assign mem_wd = (r_state == S_WRITE) ? PIX_EDGE : i_pixel_in;
    assign mem_ra = (r_state == S_FETCH) ? fetch_addr : r_rd_addr;

    eegc_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH)
    ) u_frame (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd),
        .i_rd_addr (mem_ra),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Result path: read in flight, output register, skid register.
    // At most two beats are held or in flight at once.
    // ---------------------------------------------------------------
    logic             r_pend_last;
    logic [PIX_W-1:0] r_out_pix, r_skid_pix;
    logic             r_out_last, r_skid_last;
    logic             pop;

    assign pop = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v   <= 1'b0;
            r_skid_v  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= rd_acc;
            if (!r_out_v || pop) begin
                r_out_v  <= r_skid_v || r_rd_pend;
                r_skid_v <= r_skid_v && r_rd_pend;
            end else if (r_rd_pend) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_acc) begin
            r_pend_last <= rd_last;
        end
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out_pix  <= r_skid_pix;
                r_out_last <= r_skid_last;
                r_skid_pix  <= rd_data;
                r_skid_last <= r_pend_last;
            end else begin
                r_out_pix  <= rd_data;
                r_out_last <= r_pend_last;
            end
        end else if (r_rd_pend) begin
            r_skid_pix  <= rd_data;
            r_skid_last <= r_pend_last;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_pixel_out  = r_out_pix;
    assign o_last_pixel = r_out_last;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while output register is empty");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_v && r_skid_v && r_rd_pend))
        else $error("read returned with no room to hold it");

    a_eval_after_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_SHIFT))
        else $error("window evaluated without a fresh column");

    a_center_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ((r_rc != '0) && (r_rc < wm1) &&
                                 (r_rr != '0) && (r_rr < hm1)))
        else $error("window center outside the frame interior");

    a_no_load_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready && !o_cfg_ready)
        else $error("input taken during a pass");
`endif

endmodule
